[hdl/c8ic_pkg.sv]
package c8ic_pkg;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // datapath commands from the controller
  typedef struct packed {
    logic       latch_in;     // capture input word
    logic       mem_rd;       // issue memory read
    logic [1:0] rd_sel;       // 0 item address, 1 pc, 2 pc+1, 3 index+k
    logic       mem_wr;       // write memory
    logic [1:0] wr_sel;       // 0 load data, 1 bcd digit, 2 register k
    logic       cap_hi;       // capture opcode high byte
    logic       cap_lo;       // capture opcode low byte
    logic       cap_rd;       // capture read data
    logic       exec;         // execute decoded opcode
    logic       reg_ld;       // load register k from memory data
    logic       k_clr;        // clear transfer counter
    logic       k_inc;        // advance transfer counter
    logic       fin;          // finish item (timers, pc)
    logic       out_load;     // load output register
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       halt;
    logic       is_bcd;
    logic       is_st;
    logic       is_ld;
    logic       k_last;
    logic       k_bcd_last;
  } sts_t;

endpackage

[hdl/c8ic_ctrl.sv]
module c8ic_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  c8ic_pkg::sts_t sts,
  output c8ic_pkg::ctl_t ctl
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DISP  = 11'b00000000010,
    S_RDW   = 11'b00000000100,
    S_F1    = 11'b00000001000,
    S_F2    = 11'b00000010000,
    S_F3    = 11'b00000100000,
    S_EXEC  = 11'b00001000000,
    S_BLK   = 11'b00010000000,
    S_BLKR  = 11'b00100000000,
    S_FIN   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.latch_in = 1'b1;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.cmd)
          c8ic_pkg::CMD_LOAD: begin
            ctl.mem_wr = 1'b1;
            ctl.wr_sel = 2'd0;
            state_next = S_OUT;
          end
          c8ic_pkg::CMD_STEP: begin
            ctl.mem_rd = 1'b1;
            ctl.rd_sel = 2'd1;
            state_next = S_F1;
          end
          c8ic_pkg::CMD_READ: begin
            ctl.mem_rd = 1'b1;
            ctl.rd_sel = 2'd0;
            state_next = S_RDW;
          end
          default: state_next = S_OUT;
        endcase
      end
      S_RDW: begin
        ctl.cap_rd = 1'b1;
        state_next = S_OUT;
      end
      S_F1: begin
        ctl.cap_hi = 1'b1;
        ctl.mem_rd = 1'b1;
        ctl.rd_sel = 2'd2;
        state_next = S_F2;
      end
      S_F2: begin
        ctl.cap_lo = 1'b1;
        state_next = S_F3;
      end
      S_F3: begin
        ctl.k_clr = 1'b1;
        if (sts.halt) state_next = S_OUT;
        else if (sts.is_bcd || sts.is_st || sts.is_ld) state_next = S_BLK;
        else state_next = S_EXEC;
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = S_FIN;
      end
      S_BLK: begin
        if (sts.is_ld) begin
          ctl.mem_rd = 1'b1;
          ctl.rd_sel = 2'd3;
          state_next = S_BLKR;
        end else begin
          ctl.mem_wr = 1'b1;
          ctl.wr_sel = sts.is_bcd ? 2'd1 : 2'd2;
          ctl.k_inc  = 1'b1;
          if ((sts.is_bcd && sts.k_bcd_last) || (sts.is_st && sts.k_last))
            state_next = S_FIN;
        end
      end
      S_BLKR: begin
        ctl.reg_ld = 1'b1;
        ctl.k_inc  = 1'b1;
        state_next = sts.k_last ? S_FIN : S_BLK;
      end
      S_FIN: begin
        ctl.fin    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        ctl.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> out_valid) else $error("result lost");
  a_no_wr_rd: assert property (@(posedge clk) disable iff (rst)
    !(ctl.mem_wr && ctl.mem_rd)) else $error("memory port conflict");
`endif

endmodule

[hdl/c8ic_dpath.sv]
module c8ic_dpath #(
  parameter int MEM_BYTES   = 4096,
  parameter int STACK_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  c8ic_pkg::ctl_t ctl,
  output c8ic_pkg::sts_t sts,
  input  logic [29:0]    in_word,
  output logic [71:0]    out_word
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int SW = $clog2(STACK_DEPTH);

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  mem_q;
  logic [7:0]  v [16];
  logic [11:0] stk [STACK_DEPTH];
  logic [11:0] pc, ir;
  logic [SW-1:0] sp;
  logic [7:0]  dt, st;
  logic [1:0]  cmd;
  logic [11:0] addr;
  logic [7:0]  din, rnd;
  logic [15:0] op;
  logic [7:0]  rdat;
  logic        halt;
  logic [3:0]  k;
  logic        skip, jump;
  logic [7:0]  bcd_h, bcd_t, bcd_o;

  logic [3:0]  x, y, n;
  logic [7:0]  kk, vx, vy;
  assign x  = op[11:8];
  assign y  = op[7:4];
  assign n  = op[3:0];
  assign kk = op[7:0];
  assign vx = v[x];
  assign vy = v[y];

  // bcd digits via small compare chain
  always_comb begin
    logic [7:0] r;
    r = vx;
    bcd_h = (r >= 8'd200) ? 8'd2 : (r >= 8'd100) ? 8'd1 : 8'd0;
    r = r - 8'((bcd_h * 8'd100));
    bcd_t = 8'd0;
    for (int i = 9; i >= 1; i--) begin
      if (bcd_t == 8'd0 && r >= 8'(i * 10)) bcd_t = 8'(i);
    end
    bcd_o = r - 8'(bcd_t * 8'd10);
  end

  // decode check for halt
  logic bad;
  always_comb begin
    bad = 1'b0;
    case (op[15:12])
      4'h0: bad = !(op == 16'h00E0 || op == 16'h00EE);
      4'h8: bad = !(n <= 4'h7 || n == 4'hE);
      4'h9: bad = (n != 4'h0);
      4'hE: bad = !(kk == 8'h9E || kk == 8'hA1);
      4'hF: bad = !(kk == 8'h07 || kk == 8'h0A || kk == 8'h15 || kk == 8'h18 ||
                    kk == 8'h1E || kk == 8'h29 || kk == 8'h33 || kk == 8'h55 ||
                    kk == 8'h65);
      default: bad = 1'b0;
    endcase
  end

  assign sts.cmd        = cmd;
  assign sts.halt       = bad;
  assign sts.is_bcd     = (op[15:12] == 4'hF) && (kk == 8'h33);
  assign sts.is_st      = (op[15:12] == 4'hF) && (kk == 8'h55);
  assign sts.is_ld      = (op[15:12] == 4'hF) && (kk == 8'h65);
  assign sts.k_last     = (k == x);
  assign sts.k_bcd_last = (k == 4'd2);

  logic [11:0] ik;
  assign ik = ir + {8'd0, k};

  logic [AW-1:0] ra, wa;
  logic [7:0]    wd;
  always_comb begin
    case (ctl.rd_sel)
      2'd0:    ra = addr[AW-1:0];
      2'd1:    ra = pc[AW-1:0];
      2'd2:    ra = AW'(pc + 12'd1);
      default: ra = ik[AW-1:0];
    endcase
    wa = (ctl.wr_sel == 2'd0) ? addr[AW-1:0] : ik[AW-1:0];
    case (ctl.wr_sel)
      2'd0:    wd = din;
      2'd1:    wd = (k == 4'd0) ? bcd_h : (k == 4'd1) ? bcd_t : bcd_o;
      default: wd = v[k];
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_wr) mem[wa] <= wd;
    if (ctl.mem_rd) mem_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd  <= in_word[1:0];
      addr <= in_word[13:2];
      din  <= in_word[21:14];
      rnd  <= in_word[29:22];
      op   <= 16'd0;
      rdat <= 8'd0;
    end
    if (ctl.cap_hi) op[15:8] <= mem_q;
    if (ctl.cap_lo) op[7:0] <= mem_q;
    if (ctl.cap_rd) rdat <= mem_q;
    if (ctl.k_clr) k <= 4'd0;
    else if (ctl.k_inc) k <= k + 4'd1;
    if (ctl.exec && op[15:12] == 4'h2) stk[SW'(sp + SW'(1))] <= pc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) v[i] <= 8'd0;
      pc   <= '0;
      ir   <= '0;
      sp   <= '0;
      dt   <= '0;
      st   <= '0;
      skip <= 1'b0;
      jump <= 1'b0;
      halt <= 1'b0;
    end else begin
      if (ctl.latch_in) begin
        halt <= 1'b0;
        skip <= 1'b0;
        jump <= 1'b0;
      end
      if (ctl.cap_lo) halt <= 1'b0;
      if (ctl.k_clr) halt <= bad;
      if (ctl.reg_ld) v[k] <= mem_q;
      if (ctl.exec) begin
        case (op[15:12])
          4'h0: if (op == 16'h00EE) begin
            pc <= stk[sp];
            sp <= sp - SW'(1);
          end
          4'h1: begin pc <= op[11:0]; jump <= 1'b1; end
          4'h2: begin sp <= sp + SW'(1); pc <= op[11:0]; jump <= 1'b1; end
          4'h3: skip <= (vx == kk);
          4'h4: skip <= (vx != kk);
          4'h5: skip <= (vx == vy);
          4'h6: v[x] <= kk;
          4'h7: v[x] <= vx + kk;
          4'h8: begin
            case (n)
              4'h0: v[x] <= vy;
              4'h1: v[x] <= vx | vy;
              4'h2: v[x] <= vx & vy;
              4'h3: v[x] <= vx ^ vy;
              4'h4: begin
                v[x]  <= vx + vy;
                v[15] <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'd255};
              end
              4'h5: begin v[x] <= vx - vy; v[15] <= {7'd0, vx >= vy}; end
              4'h6: begin v[x] <= vx >> 1; v[15] <= {7'd0, vx[0]}; end
              4'h7: begin v[x] <= vy - vx; v[15] <= {7'd0, vy >= vx}; end
              default: begin v[x] <= vx << 1; v[15] <= {7'd0, vx[7]}; end
            endcase
          end
          4'h9: skip <= (vx != vy);
          4'hA: ir <= op[11:0];
          4'hB: begin pc <= op[11:0] + {4'd0, v[0]}; jump <= 1'b1; end
          4'hC: v[x] <= kk & rnd;
          4'hF: begin
            case (kk)
              8'h07: v[x] <= dt;
              8'h15: dt <= vx;
              8'h18: st <= vx;
              8'h1E: ir <= ir + {4'd0, vx};
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      if (ctl.fin) begin
        if (!jump) pc <= pc + (skip ? 12'd4 : 12'd2);
        if (dt != 8'd0) dt <= dt - 8'd1;
        if (st != 8'd0) st <= st - 8'd1;
      end
    end
  end

  assign out_word = {7'd0, st, dt, halt, rdat, ir, op, pc};

endmodule

[hdl/chip8_instruction_core_top.sv]
// chip8 instruction core
// slave channel s_axis: one word per command (load byte, step, read byte)
// master channel m_axis: exactly one result word per command, in order
// all memory traffic goes through one memory port: two reads fetch the opcode,
// fx55 and fx33 move one byte a cycle, and fx65 takes a read state and then a
// register load state for each byte
// s_axis_tready is high only in idle with no result pending, so the next
// command is taken at the earliest the cycle after the result word leaves
// a stalled receiver holds the result word; the next command waits
// reset clears pc, index, registers, stack pointer and timers;
// memory and the return stack hold garbage until written
module chip8_instruction_core_top #(
  parameter int MEM_BYTES   = 4096,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[1:0], address[13:2], data[21:14], random_value[29:22]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // program_counter[11:0], opcode[27:12], index_value[39:28], read_data[47:40],
  // halted[48], delay_timer[56:49], sound_timer[64:57]
  output logic [71:0] m_axis_tdata
);

  c8ic_pkg::ctl_t ctl;
  c8ic_pkg::sts_t sts;
  logic [71:0]    res;
  logic [71:0]    res_q;

  c8ic_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .sts(sts), .ctl(ctl)
  );

  c8ic_dpath #(.MEM_BYTES(MEM_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_dpath (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .in_word(s_axis_tdata[29:0]), .out_word(res)
  );

  // output register holds the word while the receiver stalls
  always_ff @(posedge clk) begin
    if (ctl.out_load) res_q <= res;
  end
  assign m_axis_tdata = res_q;

endmodule
